### rtl/tnds_pkg.sv
// Shared constants and control types for the top-N dot product search unit.
package tnds_pkg;

    localparam int VECTOR_LENGTH_MAX_DEF = 256;
    localparam int TOP_MAX_DEF           = 8;

    localparam int ELEM_W  = 16;
    localparam int ID_W    = 24;
    localparam int SCORE_W = 40;
    localparam int PROD_W  = 32;
    localparam int CFG_W   = 4;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 64;

    // s_tuser bit positions
    localparam int IN_USER_MODE      = 0;
    localparam int IN_USER_LAST_WORD = 1;

    // item kinds carried in s_tuser mode bit
    localparam logic MODE_QUERY     = 1'b0;
    localparam logic MODE_CANDIDATE = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // -1.0 in Q10.30, marks an empty slot
    localparam logic signed [SCORE_W-1:0] SCORE_EMPTY = 40'shFF_C000_0000;
    localparam logic signed [SCORE_W-1:0] ACC_MAX     = 40'sh7F_FFFF_FFFF;
    localparam logic signed [SCORE_W-1:0] ACC_MIN     = 40'sh80_0000_0000;

    typedef struct packed {
        logic accept;     // input item taken this cycle
        logic mul_en;     // form product
        logic acc_en;     // add product into score
        logic ins_en;     // insert score into list, clear score
        logic emit_load;  // load one ranked entry into output register
        logic emit_last;  // final entry of the scan, empty the list
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_mode;
        logic in_last_el;
        logic in_last_wd;
        logic out_free;   // output register can take a new entry
    } sts_t;

endpackage

### rtl/tnds_ctrl.sv
// Controller state machine for the top-N dot product search unit.
module tnds_ctrl #(
    parameter int TOP_MAX = tnds_pkg::TOP_MAX_DEF,
    localparam int NW = $clog2(TOP_MAX + 1),
    localparam int KW = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tnds_pkg::sts_t   sts,
    input  logic [NW-1:0]    slots,
    output logic             in_ready,
    output tnds_pkg::cmd_t   cmd,
    output logic [KW-1:0]    emit_idx
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic          last_el_reg, last_wd_reg;
    logic [KW-1:0] k_reg, k_next;
    logic          accept;
    logic          k_is_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = sts.in_valid && in_ready;
    assign k_is_last = (NW'(k_reg) == slots - NW'(1));
    assign emit_idx  = k_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.mul_en    = (state_reg == S_MUL);
        cmd.acc_en    = (state_reg == S_ACC);
        cmd.ins_en    = (state_reg == S_INS);
        cmd.emit_load = (state_reg == S_EMIT) && sts.out_free;
        cmd.emit_last = cmd.emit_load && k_is_last;
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (sts.in_mode == tnds_pkg::MODE_CANDIDATE))
                    state_next = S_MUL;
            end
            S_MUL:
                state_next = S_ACC;
            S_ACC:
                state_next = last_el_reg ? S_INS : S_IDLE;
            S_INS:
            begin
                k_next     = '0;
                state_next = last_wd_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (k_is_last)
                        state_next = S_IDLE;
                    else
                        k_next = k_reg + KW'(1);
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            last_el_reg <= 1'b0;
            last_wd_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (accept)
            begin
                last_el_reg <= sts.in_last_el;
                last_wd_reg <= sts.in_last_wd;
            end
        end
    end

`ifndef ASSERT_OFF
    // rank counter stays inside the slots in use while emitting
    a_emit_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (NW'(k_reg) < slots))
        else $error("emit index beyond slots in use");

    // insertion only follows the final element of a candidate
    a_ins_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |-> ($past(state_reg) == S_ACC) && last_el_reg)
        else $error("insert without candidate end");
`endif

endmodule

### rtl/tnds_list.sv
// Ranked top-N score list with parallel compare and shift-down insert.
module tnds_list #(
    parameter int TOP_MAX = tnds_pkg::TOP_MAX_DEF,
    localparam int NW = $clog2(TOP_MAX + 1),
    localparam int KW = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 ins_en,
    input  logic signed [tnds_pkg::SCORE_W-1:0]  ins_score,
    input  logic [tnds_pkg::ID_W-1:0]            ins_id,
    input  logic [NW-1:0]                        slots,
    input  logic                                 clear,
    input  logic [KW-1:0]                        rd_idx,
    output logic signed [tnds_pkg::SCORE_W-1:0]  rd_score,
    output logic [tnds_pkg::ID_W-1:0]            rd_id,
    output logic                                 rd_filled
);

    logic signed [tnds_pkg::SCORE_W-1:0] score_reg [TOP_MAX];
    logic [tnds_pkg::ID_W-1:0]           id_reg    [TOP_MAX];
    logic [TOP_MAX-1:0]                  filled_reg;
    logic [TOP_MAX-1:0]                  in_use, hit, shift_dn;

    always_comb
    begin
        for (int i = 0; i < TOP_MAX; i++)
        begin
            in_use[i] = (NW'(i) < slots);
            hit[i]    = in_use[i] && (ins_score > score_reg[i]);
        end
        // shift_dn[i]: insertion point lies above slot i, so slot i shifts down
        shift_dn[0] = 1'b0;
        for (int i = 1; i < TOP_MAX; i++)
            shift_dn[i] = shift_dn[i-1] | hit[i-1];
    end

    for (genvar i = 0; i < TOP_MAX; i++)
    begin : g_slot
        logic signed [tnds_pkg::SCORE_W-1:0] up_score;
        logic [tnds_pkg::ID_W-1:0]           up_id;
        logic                                up_filled;

        if (i == 0)
        begin : g_head
            assign up_score  = ins_score;
            assign up_id     = ins_id;
            assign up_filled = 1'b1;
        end
        else
        begin : g_body
            assign up_score  = score_reg[i-1];
            assign up_id     = id_reg[i-1];
            assign up_filled = filled_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                score_reg[i]  <= tnds_pkg::SCORE_EMPTY;
                id_reg[i]     <= '0;
                filled_reg[i] <= 1'b0;
            end
            else if (clear)
            begin
                score_reg[i]  <= tnds_pkg::SCORE_EMPTY;
                id_reg[i]     <= '0;
                filled_reg[i] <= 1'b0;
            end
            else if (ins_en && in_use[i])
            begin
                if (shift_dn[i])
                begin
                    score_reg[i]  <= up_score;
                    id_reg[i]     <= up_id;
                    filled_reg[i] <= up_filled;
                end
                else if (hit[i])
                begin
                    score_reg[i]  <= ins_score;
                    id_reg[i]     <= ins_id;
                    filled_reg[i] <= 1'b1;
                end
            end
        end
    end

    assign rd_score  = score_reg[rd_idx];
    assign rd_id     = id_reg[rd_idx];
    assign rd_filled = filled_reg[rd_idx];

`ifndef ASSERT_OFF
    // end of scan leaves every slot empty
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (filled_reg == '0) && (score_reg[0] == tnds_pkg::SCORE_EMPTY))
        else $error("list not emptied after scan");
`endif

endmodule

### rtl/tnds_dp.sv
// Datapath: query memory, multiply-accumulate, score list and output register.
module tnds_dp #(
    parameter int VECTOR_LENGTH_MAX = tnds_pkg::VECTOR_LENGTH_MAX_DEF,
    parameter int TOP_MAX           = tnds_pkg::TOP_MAX_DEF,
    localparam int NW = $clog2(TOP_MAX + 1),
    localparam int KW = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1,
    localparam int PW = $clog2(VECTOR_LENGTH_MAX + 1),
    localparam int AW = (VECTOR_LENGTH_MAX > 1) ? $clog2(VECTOR_LENGTH_MAX) : 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tnds_pkg::cmd_t                        cmd,
    input  logic [KW-1:0]                         emit_idx,
    input  logic [tnds_pkg::IN_TDATA_W-1:0]       in_data,
    input  logic [tnds_pkg::IN_TUSER_W-1:0]       in_user,
    input  logic                                  in_last,
    input  logic                                  cfg_valid,
    input  logic [tnds_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [tnds_pkg::OUT_TDATA_W-1:0]      out_data,
    output logic                                  out_user,
    output logic                                  out_last,
    output logic                                  out_free,
    output logic [NW-1:0]                         slots
);

    localparam int SW = tnds_pkg::SCORE_W;

    logic signed [tnds_pkg::ELEM_W-1:0] qmem [VECTOR_LENGTH_MAX];
    logic signed [tnds_pkg::ELEM_W-1:0] q_rd_reg;
    logic signed [tnds_pkg::ELEM_W-1:0] elem_reg;
    logic [tnds_pkg::ID_W-1:0]          id_reg;
    logic                               range_reg;
    logic signed [tnds_pkg::PROD_W-1:0] prod_reg;
    logic signed [SW-1:0]               acc_reg, acc_sat;
    logic signed [SW:0]                 acc_sum;
    logic [PW-1:0]                      pos_reg;
    logic [tnds_pkg::CFG_W-1:0]         cfg_reg;

    logic signed [tnds_pkg::ELEM_W-1:0] in_elem;
    logic [tnds_pkg::ID_W-1:0]          in_id;
    logic                               in_mode, in_range;
    logic [AW-1:0]                      addr;

    logic signed [SW-1:0]               rd_score;
    logic [tnds_pkg::ID_W-1:0]          rd_id;
    logic                               rd_filled;

    logic                               out_valid_reg, out_filled_reg, out_last_reg;
    logic signed [SW-1:0]               out_score_reg;
    logic [tnds_pkg::ID_W-1:0]          out_id_reg;

    assign in_elem  = in_data[tnds_pkg::ELEM_W-1:0];
    assign in_id    = in_data[tnds_pkg::ELEM_W +: tnds_pkg::ID_W];
    assign in_mode  = in_user[tnds_pkg::IN_USER_MODE];
    assign in_range = (pos_reg < PW'(VECTOR_LENGTH_MAX));
    assign addr     = pos_reg[AW-1:0];

    // neighbor count: zero means one, clamp at list depth
    always_comb
    begin
        priority if (cfg_reg == '0)
            slots = NW'(1);
        else if (int'(cfg_reg) > TOP_MAX)
            slots = NW'(TOP_MAX);
        else
            slots = NW'(cfg_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= tnds_pkg::CFG_RESET;
        else if (cfg_valid)
            cfg_reg <= cfg_data;
    end

    // query store, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (in_mode == tnds_pkg::MODE_QUERY) && in_range)
            qmem[addr] <= in_elem;
        if (cmd.accept && (in_mode == tnds_pkg::MODE_CANDIDATE))
            q_rd_reg <= qmem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            elem_reg  <= in_elem;
            id_reg    <= in_id;
            range_reg <= in_range;
        end
        if (cmd.mul_en)
        begin
            // signed product; elements past the vector length add nothing
            if (range_reg)
                prod_reg <= q_rd_reg * elem_reg;
            else
                prod_reg <= '0;
        end
    end

    assign acc_sum = {acc_reg[SW-1], acc_reg} + (SW+1)'(prod_reg);

    always_comb
    begin
        priority if (acc_sum[SW] != acc_sum[SW-1])
            acc_sat = acc_sum[SW] ? tnds_pkg::ACC_MIN : tnds_pkg::ACC_MAX;
        else
            acc_sat = acc_sum[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (in_last)
                    pos_reg <= '0;
                else if (in_range)
                    pos_reg <= pos_reg + PW'(1);
                if (in_last && (in_mode == tnds_pkg::MODE_QUERY))
                    acc_reg <= '0;
            end
            if (cmd.acc_en)
                acc_reg <= acc_sat;
            else if (cmd.ins_en)
                acc_reg <= '0;
        end
    end

    tnds_list #(
        .TOP_MAX   (TOP_MAX)
    ) u_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .ins_en    (cmd.ins_en),
        .ins_score (acc_reg),
        .ins_id    (id_reg),
        .slots     (slots),
        .clear     (cmd.emit_last),
        .rd_idx    (emit_idx),
        .rd_score  (rd_score),
        .rd_id     (rd_id),
        .rd_filled (rd_filled)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_score_reg  <= rd_score;
            out_id_reg     <= rd_id;
            out_filled_reg <= rd_filled;
            out_last_reg   <= cmd.emit_last;
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = {out_score_reg, out_id_reg};
    assign out_user  = out_filled_reg;
    assign out_last  = out_last_reg;

`ifndef ASSERT_OFF
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(VECTOR_LENGTH_MAX))
        else $error("element position beyond vector length");

    a_score_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_en |=> (acc_reg == '0))
        else $error("score not cleared after insert");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> out_free)
        else $error("output entry overwritten before taken");
`endif

endmodule

### rtl/top_n_dot_product_search_unit.sv
// Top level of the top-N dot product search unit.
//
// Input stream (s_*): mode 0 items load query elements in order; mode 1 items
// stream candidate elements, each multiplied by the query element at the same
// position and summed as a Q10.30 score. s_tlast ends a vector; on a
// candidate's end the score enters a descending top-N list. s_tuser[1]
// together with s_tlast on a candidate ends the scan.
// Output stream (m_*): after the scan, one item per rank slot, best first,
// m_tlast on the final one; the list is then emptied.
// Config (cfg_*): neighbor count, always ready, write only while idle.
// Sequence: a query element is stored while idle; a candidate element passes
// query memory read, multiply and saturating add in turn on the one shared
// MAC before the next item is taken. A candidate end adds an insert step; a
// scan end then loads one result per cycle while m_tready is high.
// A stalled receiver holds the output register and the result sequencer; no
// input item is taken until all results are loaded.
// Reset: list empty (score -1.0), position and score zero, count 8. The
// query memory is not cleared and must be loaded before use.
module top_n_dot_product_search_unit #(
    parameter int VECTOR_LENGTH_MAX = tnds_pkg::VECTOR_LENGTH_MAX_DEF,
    parameter int TOP_MAX           = tnds_pkg::TOP_MAX_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [15:0] element_value, [39:16] word_id
    input  logic [tnds_pkg::IN_TDATA_W-1:0]       s_tdata,
    // [0] mode, [1] last_word
    input  logic [tnds_pkg::IN_TUSER_W-1:0]       s_tuser,
    input  logic                                  s_tlast,   // last_element
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [23:0] neighbor_id, [63:24] neighbor_score
    output logic [tnds_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // [0] slot_filled
    output logic                                  m_tuser,
    output logic                                  m_tlast,   // last_result
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tnds_pkg::CFG_W-1:0]            cfg_data   // neighbors_in_use
);

    localparam int NW = $clog2(TOP_MAX + 1);
    localparam int KW = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1;

    tnds_pkg::cmd_t cmd;
    tnds_pkg::sts_t sts;
    logic [KW-1:0]  emit_idx;
    logic [NW-1:0]  slots;
    logic           out_free;

    assign cfg_ready = 1'b1;

    assign sts.in_valid   = s_tvalid;
    assign sts.in_mode    = s_tuser[tnds_pkg::IN_USER_MODE];
    assign sts.in_last_el = s_tlast;
    assign sts.in_last_wd = s_tuser[tnds_pkg::IN_USER_LAST_WORD];
    assign sts.out_free   = out_free;

    tnds_ctrl #(
        .TOP_MAX  (TOP_MAX)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .slots    (slots),
        .in_ready (s_tready),
        .cmd      (cmd),
        .emit_idx (emit_idx)
    );

    tnds_dp #(
        .VECTOR_LENGTH_MAX (VECTOR_LENGTH_MAX),
        .TOP_MAX           (TOP_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .emit_idx  (emit_idx),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .in_last   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast),
        .out_free  (out_free),
        .slots     (slots)
    );

endmodule
